/* hdl/motion_profile_pd_drive_core_assert.svh */
// assertion macros for the drive core checker
`ifndef MOTION_PROFILE_PD_DRIVE_CORE_ASSERT_SVH
`define MOTION_PROFILE_PD_DRIVE_CORE_ASSERT_SVH

// antecedent holds, consequent holds on the same edge
`define MPPD_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// antecedent holds, consequent holds on the next edge
`define MPPD_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

/* hdl/mppd_pkg.sv */
`timescale 1ns / 1ps
package mppd_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int MUL_A_W     = 17;
   localparam int MUL_B_W     = 36;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   localparam logic [CSR_INDEX_W-1:0] REG_FWD_P   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FWD_D   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TURN_P  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TURN_D  = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WALL_P  = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WALL_D  = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_FWD_ACC = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_FWD_DEC = 4'd7;

   typedef struct packed {
      logic [15:0] fwd_p;
      logic [15:0] fwd_d;
      logic [15:0] turn_p;
      logic [15:0] turn_d;
      logic [15:0] wall_p;
      logic [15:0] wall_d;
      logic [15:0] fwd_acc;
      logic [15:0] fwd_dec;
   } csr_type;

endpackage

/* hdl/mppd_csr.sv */
`timescale 1ns / 1ps
module mppd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [mppd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mppd_pkg::CSR_DATA_W-1:0]    csr_data,
   output mppd_pkg::csr_type                  regs
);
   import mppd_pkg::*;

   csr_type regs_ff;
   csr_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         case (csr_index)
            REG_FWD_P:   regs_in.fwd_p   = csr_data;
            REG_FWD_D:   regs_in.fwd_d   = csr_data;
            REG_TURN_P:  regs_in.turn_p  = csr_data;
            REG_TURN_D:  regs_in.turn_d  = csr_data;
            REG_WALL_P:  regs_in.wall_p  = csr_data;
            REG_WALL_D:  regs_in.wall_d  = csr_data;
            REG_FWD_ACC: regs_in.fwd_acc = csr_data;
            REG_FWD_DEC: regs_in.fwd_dec = csr_data;
            default:     regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.fwd_p   <= 16'd243;
         regs_ff.fwd_d   <= 16'd2560;
         regs_ff.turn_p  <= 16'd205;
         regs_ff.turn_d  <= 16'd4352;
         regs_ff.wall_p  <= 16'd218;
         regs_ff.wall_d  <= 16'd1792;
         regs_ff.fwd_acc <= 16'd256;
         regs_ff.fwd_dec <= 16'd512;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

/* hdl/mppd_mul.sv */
`timescale 1ns / 1ps
module mppd_mul (
   input  logic                                clock,
   input  logic signed [mppd_pkg::MUL_A_W-1:0] op_a,
   input  logic signed [mppd_pkg::MUL_B_W-1:0] op_b,
   output logic signed [mppd_pkg::MUL_P_W-1:0] prod
);
   import mppd_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* hdl/motion_profile_pd_drive_core.sv */
`timescale 1ns / 1ps
// channel   dir   handshake             payload
// req_      in    req_valid/req_stall   counts, gyro, ir levels, targets
// rsp_      out   rsp_valid/rsp_stall   left/right drive, ramped speeds
// csr_      in    csr_write             csr_index, csr_data
//
// each item is accepted, then runs 12 steps of the shared multiplier
// sequencer; a finished result sits in the output register so the next item
// can start while it waits, but the last step holds while rsp_stall keeps
// the previous result. synchronous active-high reset clears all loop state.
module motion_profile_pd_drive_core #(
   parameter int TURN_ACCEL_STEP = 256,
   parameter int TURN_DECEL_STEP = 256,
   parameter int WALL_MIX_WEIGHT = 0,
   parameter int GYRO_RECIP_Q16  = -293
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [mppd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mppd_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_left_count,
   input  logic signed [31:0]                req_right_count,
   input  logic signed [15:0]                req_gyro_rate,
   input  logic [7:0]                        req_ir_left_level,
   input  logic [7:0]                        req_ir_right_level,
   input  logic signed [15:0]                req_target_forward,
   input  logic signed [15:0]                req_target_turn,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_left_drive,
   output logic signed [15:0]                rsp_right_drive,
   output logic signed [23:0]                rsp_forward_speed_now,
   output logic signed [23:0]                rsp_turn_speed_now
);
   import mppd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   localparam logic [3:0] STEP_GYRO  = 4'd0;
   localparam logic [3:0] STEP_FERR  = 4'd1;
   localparam logic [3:0] STEP_FP    = 4'd2;
   localparam logic [3:0] STEP_FD    = 4'd3;
   localparam logic [3:0] STEP_RP    = 4'd4;
   localparam logic [3:0] STEP_RD    = 4'd5;
   localparam logic [3:0] STEP_WP    = 4'd6;
   localparam logic [3:0] STEP_WD    = 4'd7;
   localparam logic [3:0] STEP_MIXR  = 4'd8;
   localparam logic [3:0] STEP_MIXW  = 4'd9;
   localparam logic [3:0] STEP_MIX   = 4'd10;
   localparam logic [3:0] STEP_OUT   = 4'd11;

   function automatic logic signed [23:0] ramp(input logic signed [23:0] s,
                                               input logic signed [23:0] t,
                                               input logic [15:0] acc,
                                               input logic [15:0] dec);
      logic signed [25:0] n;
      logic signed [25:0] tw;
      n  = 26'(s);
      tw = 26'(t);
      if (s < t) begin
         n = n + $signed({10'd0, (s >= 0) ? acc : dec});
         if (n > tw) n = tw;
      end else if (s > t) begin
         n = n - $signed({10'd0, (s > 0) ? dec : acc});
         if (n < tw) n = tw;
      end
      return n[23:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647) r = 32'sh7fffffff;
      else if (v < -43'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
      logic signed [15:0] r;
      if (v > 38'sd32767) r = 16'sh7fff;
      else if (v < -38'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

   csr_type regs;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_load;
   logic accept;

   logic [31:0]        lc_ff, rc_ff, prev_l_ff, prev_r_ff;
   logic signed [15:0] gyro_ff, tf_ff, tt_ff;
   logic [7:0]         irl_ff, irr_ff;

   logic signed [23:0] spd_f_ff, spd_f_in, spd_r_ff, spd_r_in;
   logic signed [31:0] err_f_ff, err_f_in, err_r_ff, err_r_in;
   logic signed [31:0] last_f_ff, last_f_in, last_r_ff, last_r_in;
   logic signed [9:0]  ewall_ff, ewall_in, last_w_ff, last_w_in;
   logic signed [32:0] sum_ff, sum_in, dif_ff, dif_in;
   logic signed [24:0] fb_ff, fb_in;
   logic signed [MUL_P_W-1:0] acc_ff, acc_in;
   logic signed [33:0] pf_ff, pf_in, pr_ff, pr_in, pw_ff, pw_in;
   logic signed [43:0] mix_ff, mix_in;
   logic signed [15:0] left_ff, left_in, right_ff, right_in;
   logic signed [23:0] out_f_ff, out_f_in, out_r_ff, out_r_in;

   logic signed [MUL_A_W-1:0] op_a;
   logic signed [MUL_B_W-1:0] op_b;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [MUL_P_W:0]   psum;
   logic signed [MUL_P_W:0]   psum_t16, psum_t8;
   logic signed [32:0]        dl, dr;
   logic signed [9:0]         irl_s, irr_s;
   logic signed [45:0]        fwd256, ldiff, rdiff;
   logic signed [45:0]        ltr, rtr;

   mppd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .regs      (regs)
   );

   mppd_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_RUN) && (step_ff == STEP_OUT) &&
                      (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         STEP_GYRO: begin
            op_a = MUL_A_W'(GYRO_RECIP_Q16);
            op_b = MUL_B_W'(gyro_ff);
         end
         STEP_FP: begin
            op_a = $signed({1'b0, regs.fwd_p});
            op_b = MUL_B_W'(err_f_ff);
         end
         STEP_FD: begin
            op_a = $signed({1'b0, regs.fwd_d});
            op_b = MUL_B_W'(dif_ff);
         end
         STEP_RP: begin
            op_a = $signed({1'b0, regs.turn_p});
            op_b = MUL_B_W'(err_r_ff);
         end
         STEP_RD: begin
            op_a = $signed({1'b0, regs.turn_d});
            op_b = MUL_B_W'(dif_ff);
         end
         STEP_WP: begin
            op_a = $signed({1'b0, regs.wall_p});
            op_b = MUL_B_W'(ewall_ff);
         end
         STEP_WD: begin
            op_a = $signed({1'b0, regs.wall_d});
            op_b = MUL_B_W'(dif_ff);
         end
         STEP_MIXR: begin
            op_a = MUL_A_W'(256 - WALL_MIX_WEIGHT);
            op_b = MUL_B_W'(pr_ff);
         end
         STEP_MIXW: begin
            op_a = MUL_A_W'(WALL_MIX_WEIGHT);
            op_b = MUL_B_W'(pw_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign psum     = (MUL_P_W+1)'(acc_ff) + (MUL_P_W+1)'(prod);
   assign psum_t16 = (psum + (psum < 0 ? (MUL_P_W+1)'(65535) : '0)) >>> 16;
   assign psum_t8  = (psum + (psum < 0 ? (MUL_P_W+1)'(255) : '0)) >>> 8;

   assign dl = 33'($signed(lc_ff - prev_l_ff));
   assign dr = 33'($signed(rc_ff - prev_r_ff));
   assign irl_s = $signed({2'b00, irl_ff});
   assign irr_s = $signed({2'b00, irr_ff});

   assign fwd256 = 46'(pf_ff) <<< 8;
   assign ldiff  = fwd256 - 46'(mix_ff);
   assign rdiff  = fwd256 + 46'(mix_ff);
   assign ltr    = (ldiff + (ldiff < 0 ? 46'sd255 : 46'sd0)) >>> 8;
   assign rtr    = (rdiff + (rdiff < 0 ? 46'sd255 : 46'sd0)) >>> 8;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      spd_f_in  = spd_f_ff;
      spd_r_in  = spd_r_ff;
      err_f_in  = err_f_ff;
      err_r_in  = err_r_ff;
      last_f_in = last_f_ff;
      last_r_in = last_r_ff;
      last_w_in = last_w_ff;
      ewall_in  = ewall_ff;
      sum_in    = sum_ff;
      dif_in    = dif_ff;
      fb_in     = fb_ff;
      acc_in    = acc_ff;
      pf_in     = pf_ff;
      pr_in     = pr_ff;
      pw_in     = pw_ff;
      mix_in    = mix_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      out_f_in  = out_f_ff;
      out_r_in  = out_r_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = STEP_GYRO;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               STEP_GYRO: begin
                  sum_in   = dl + dr;
                  spd_f_in = ramp(spd_f_ff, {tf_ff, 8'd0}, regs.fwd_acc, regs.fwd_dec);
                  if (irl_ff > 8'd170 || irr_ff > 8'd185)
                     ewall_in = (irl_ff > irr_ff) ? (10'sd215 - irl_s) : (irr_s - 10'sd225);
                  else
                     ewall_in = '0;
               end
               STEP_FERR: begin
                  fb_in    = prod[32:8];
                  spd_r_in = ramp(spd_r_ff, {tt_ff, 8'd0}, 16'(TURN_ACCEL_STEP),
                                  16'(TURN_DECEL_STEP));
                  err_f_in = sat32(43'(err_f_ff) + 43'(spd_f_ff) - (43'(sum_ff) <<< 8));
               end
               STEP_FP: begin
                  err_r_in = sat32(43'(err_r_ff) + 43'(spd_r_ff) - 43'(fb_ff));
                  dif_in   = 33'(err_f_ff) - 33'(last_f_ff);
               end
               STEP_FD: begin
                  acc_in    = prod;
                  last_f_in = err_f_ff;
                  dif_in    = 33'(err_r_ff) - 33'(last_r_ff);
               end
               STEP_RP: begin
                  pf_in = psum_t16[33:0];
               end
               STEP_RD: begin
                  acc_in    = prod;
                  last_r_in = err_r_ff;
                  dif_in    = 33'(ewall_ff - last_w_ff);
               end
               STEP_WP: begin
                  pr_in = psum_t16[33:0];
               end
               STEP_WD: begin
                  acc_in    = prod;
                  last_w_in = ewall_ff;
               end
               STEP_MIXR: begin
                  pw_in = psum_t8[33:0];
               end
               STEP_MIXW: begin
                  acc_in = prod;
               end
               STEP_MIX: begin
                  mix_in = psum[43:0];
               end
               STEP_OUT: begin
                  step_in = step_ff;
                  if (out_load) begin
                     left_in      = sat16(ltr[37:0]);
                     right_in     = sat16(rtr[37:0]);
                     out_f_in     = spd_f_ff;
                     out_r_in     = spd_r_ff;
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                     step_in      = STEP_GYRO;
                  end
               end
               default: step_in = STEP_GYRO;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_GYRO;
         rsp_valid_ff <= 1'b0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         spd_f_ff     <= '0;
         spd_r_ff     <= '0;
         err_f_ff     <= '0;
         err_r_ff     <= '0;
         last_f_ff    <= '0;
         last_r_ff    <= '0;
         last_w_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         spd_f_ff     <= spd_f_in;
         spd_r_ff     <= spd_r_in;
         err_f_ff     <= err_f_in;
         err_r_ff     <= err_r_in;
         last_f_ff    <= last_f_in;
         last_r_ff    <= last_r_in;
         last_w_ff    <= last_w_in;
         if (state_ff == ST_RUN && step_ff == STEP_GYRO) begin
            prev_l_ff <= lc_ff;
            prev_r_ff <= rc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lc_ff   <= req_left_count;
         rc_ff   <= req_right_count;
         gyro_ff <= req_gyro_rate;
         irl_ff  <= req_ir_left_level;
         irr_ff  <= req_ir_right_level;
         tf_ff   <= req_target_forward;
         tt_ff   <= req_target_turn;
      end
      ewall_ff <= ewall_in;
      sum_ff   <= sum_in;
      dif_ff   <= dif_in;
      fb_ff    <= fb_in;
      acc_ff   <= acc_in;
      pf_ff    <= pf_in;
      pr_ff    <= pr_in;
      pw_ff    <= pw_in;
      mix_ff   <= mix_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      out_f_ff <= out_f_in;
      out_r_ff <= out_r_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_left_drive        = left_ff;
   assign rsp_right_drive       = right_ff;
   assign rsp_forward_speed_now = out_f_ff;
   assign rsp_turn_speed_now    = out_r_ff;

endmodule

/* hdl/mppd_checker.sv */
`timescale 1ns / 1ps
`include "motion_profile_pd_drive_core_assert.svh"
module mppd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              csr_write,
   input logic [mppd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [mppd_pkg::CSR_DATA_W-1:0]   csr_data,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic signed [31:0]                req_left_count,
   input logic signed [31:0]                req_right_count,
   input logic signed [15:0]                req_gyro_rate,
   input logic [7:0]                        req_ir_left_level,
   input logic [7:0]                        req_ir_right_level,
   input logic signed [15:0]                req_target_forward,
   input logic signed [15:0]                req_target_turn,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [15:0]                rsp_left_drive,
   input logic signed [15:0]                rsp_right_drive,
   input logic signed [23:0]                rsp_forward_speed_now,
   input logic signed [23:0]                rsp_turn_speed_now
);

   // busy right after an item is taken
   `MPPD_ASSERT_NEXT(busy_after_accept, req_valid && !req_stall, req_stall)

   // a new result only appears at the end of a run
   `MPPD_ASSERT_NOW(rsp_from_run, $rose(rsp_valid), $past(req_stall))

   `MPPD_ASSERT_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   `MPPD_ASSERT_NEXT(rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_left_drive) && $stable(rsp_right_drive) &&
      $stable(rsp_forward_speed_now) && $stable(rsp_turn_speed_now))

endmodule

bind motion_profile_pd_drive_core mppd_checker u_mppd_checker (.*);
